// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros shared by the bond force RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPLY(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error("same-cycle implication failed");
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("next-cycle implication failed");
`else
`define ASSERT_IMPLY(lbl, clk, rst_n, pre, post)
`define ASSERT_NEXT(lbl, clk, rst_n, pre, post)
`endif
`endif

// ===== rtl/pbf_pkg.sv =====
// ----------------------------------------------------------------------------
// pbf_pkg
// Widths, register codes and word types of the bond force pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
package pbf_pkg;

  localparam int unsigned IN_W       = 32;
  localparam int unsigned D_W        = 33;
  localparam int unsigned LEN_W      = 35;
  localparam int unsigned RAD_W      = 66;
  localparam int unsigned Q_W        = 31;
  localparam int unsigned CRIT_W     = 30;
  localparam int unsigned MICRO_W    = 48;
  localparam int unsigned FORCE_W    = 48;
  localparam int unsigned STR_W      = 32;
  localparam int unsigned F_W        = 50;
  localparam int unsigned DIV_LANES  = 4;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 48;

  localparam logic [CRIT_W-1:0]    CRIT_RESET  = 30'd10737418;
  localparam logic [MICRO_W-1:0]   MICRO_RESET = 48'd18023693792051;
  localparam logic [CFG_IDX_W-1:0] CFG_CRIT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MICRO   = 2'd1;

  localparam logic [F_W-1:0]   F_POS_LIM = F_W'(48'h7FFF_FFFF_FFFF);
  localparam logic [F_W-1:0]   F_NEG_LIM = F_W'(48'h8000_0000_0000);
  localparam logic [STR_W-1:0] S_SAT     = 32'h7FFF_FFFF;

  typedef struct packed {
    logic signed [IN_W-1:0] ref_dx;
    logic signed [IN_W-1:0] ref_dy;
    logic signed [IN_W-1:0] ref_dz;
    logic signed [IN_W-1:0] rel_disp_x;
    logic signed [IN_W-1:0] rel_disp_y;
    logic signed [IN_W-1:0] rel_disp_z;
    logic                   was_broken;
    logic                   mode;
  } in_word_t;

  typedef struct packed {
    logic signed [FORCE_W-1:0] force_x;
    logic signed [FORCE_W-1:0] force_y;
    logic signed [FORCE_W-1:0] force_z;
    logic signed [STR_W-1:0]   stretch;
    logic                      broken_now;
    logic                      length_error;
  } out_word_t;

  typedef struct packed {
    logic [2:0][D_W-1:0] md;
    logic [2:0]          dneg;
    logic                was_broken;
    logic                mode;
  } sqrt_sb_t;

  typedef struct packed {
    logic       l0_zero;
    logic       l1_zero;
    logic       pos;
    logic       sat;
    logic [2:0] dneg;
    logic       was_broken;
    logic       mode;
  } div_sb_t;

  typedef struct packed {
    logic [STR_W-1:0]    stretch;
    logic [Q_W-1:0]      sm;
    logic [2:0][Q_W-1:0] u;
    logic [2:0]          dneg;
    logic                sneg;
    logic                was_broken;
    logic                l0_zero;
    logic                l1_zero;
    logic                brk;
  } force_in_t;

endpackage
`default_nettype wire

// ===== rtl/pmb_bond_force_and_break_core.sv =====
// ----------------------------------------------------------------------------
// pmb_bond_force_and_break_core
// PMB peridynamic bond: stretch, breaking check and saturated pair force.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | word
//  in      | input     | in_valid/in_ready   | in_word_t  (bond vector, disp)
//  out     | output    | out_valid/out_ready | out_word_t (force, stretch, flags)
//  cfg     | input     | cfg_we              | index + 48-bit data
//
//  One bond per cycle while the output is not stalled. Stages: 3 square/sum,
//  35 square root (one root bit each), 1 stretch setup, 31 divider (one
//  quotient bit each), 1 stretch and 4 multiply/saturate.
//  Reset clears valid bits and loads the register defaults. A stall at the
//  output freezes every stage at once; nothing is lost or repeated.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"
module pmb_bond_force_and_break_core (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  pbf_pkg::in_word_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output pbf_pkg::out_word_t                out_data_o,
  input  logic                              cfg_we_i,
  input  logic [pbf_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [pbf_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import pbf_pkg::*;

  logic                          adv;
  logic [CRIT_W-1:0]             crit_q;
  logic [MICRO_W-1:0]            micro_q;

  logic                          va_q, vb_q, vc_q, vd_q, ve_q;
  logic [2:0][IN_W-1:0]          mxi_a_q;
  sqrt_sb_t                      sb_a_d, sb_a_q, sb_b_q, sb_c_q;
  logic [2:0][IN_W-1:0]          mxi_a_d;
  logic [2:0][2*IN_W-1:0]        sqxi_b_q;
  logic [2:0][RAD_W-1:0]         sqd_b_q;
  logic [1:0][RAD_W-1:0]         rad_c_q;

  logic                          sq_valid;
  logic [1:0][LEN_W-1:0]         root;
  sqrt_sb_t                      sq_sb;

  logic [DIV_LANES-1:0][LEN_W-1:0] num_d, num_q, den_d, den_q;
  div_sb_t                       dsb_d, dsb_q;

  logic                          dv_valid;
  logic [DIV_LANES-1:0][Q_W-1:0] quo;
  div_sb_t                       dv_sb;
  force_in_t                     fin_d, fin_q;

  // advance the whole pipe unless the output word is held
  assign adv        = !out_valid_o || out_ready_i;
  assign in_ready_o = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crit_q  <= CRIT_RESET;
      micro_q <= MICRO_RESET;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == CFG_CRIT) begin
        crit_q <= cfg_data_i[CRIT_W-1:0];
      end else if (cfg_idx_i == CFG_MICRO) begin
        micro_q <= cfg_data_i[MICRO_W-1:0];
      end
    end
  end

  // stage A: deformed vector and magnitudes
  always_comb begin
    logic signed [IN_W-1:0] xi  [3];
    logic signed [IN_W-1:0] eta [3];
    logic signed [D_W-1:0]  d;
    xi[0]  = in_data_i.ref_dx;
    xi[1]  = in_data_i.ref_dy;
    xi[2]  = in_data_i.ref_dz;
    eta[0] = in_data_i.rel_disp_x;
    eta[1] = in_data_i.rel_disp_y;
    eta[2] = in_data_i.rel_disp_z;
    sb_a_d.was_broken = in_data_i.was_broken;
    sb_a_d.mode       = in_data_i.mode;
    for (int i = 0; i < 3; i++) begin
      d = D_W'(xi[i]) + D_W'(eta[i]);
      mxi_a_d[i]     = xi[i][IN_W-1] ? IN_W'(0) - IN_W'(xi[i]) : IN_W'(xi[i]);
      sb_a_d.md[i]   = d[D_W-1] ? D_W'(0) - D_W'(d) : D_W'(d);
      sb_a_d.dneg[i] = d[D_W-1];
    end
  end

  // stage D: stretch numerator, unit-vector dividends and overflow check
  always_comb begin
    logic [LEN_W-1:0] l0, l1, ns;
    logic             pos;
    l0  = root[0];
    l1  = root[1];
    pos = l1 >= l0;
    ns  = pos ? l1 - l0 : l0 - l1;
    num_d[0] = ns;
    den_d[0] = l0;
    for (int i = 0; i < 3; i++) begin
      num_d[i+1] = LEN_W'(sq_sb.md[i]);
      den_d[i+1] = l1;
    end
    dsb_d.l0_zero    = l0 == '0;
    dsb_d.l1_zero    = l1 == '0;
    dsb_d.pos        = pos;
    dsb_d.sat        = pos && ({1'b0, ns} >= {l0, 1'b0});
    dsb_d.dneg       = sq_sb.dneg;
    dsb_d.was_broken = sq_sb.was_broken;
    dsb_d.mode       = sq_sb.mode;
  end

  // stage E: signed stretch and break decision
  always_comb begin
    logic [Q_W-1:0] q;
    q = quo[0];
    fin_d.dneg       = dv_sb.dneg;
    fin_d.was_broken = dv_sb.was_broken;
    fin_d.l0_zero    = dv_sb.l0_zero;
    fin_d.l1_zero    = dv_sb.l1_zero;
    for (int i = 0; i < 3; i++) begin
      fin_d.u[i] = quo[i+1];
    end
    if (dv_sb.sat) begin
      fin_d.stretch = S_SAT;
      fin_d.sm      = S_SAT[Q_W-1:0];
    end else if (dv_sb.pos) begin
      fin_d.stretch = STR_W'(q);
      fin_d.sm      = q;
    end else begin
      fin_d.stretch = STR_W'(0) - STR_W'(q);
      fin_d.sm      = q;
    end
    fin_d.sneg = !dv_sb.pos && (q != '0);
    fin_d.brk  = !dv_sb.mode && dv_sb.pos && (fin_d.sm > Q_W'(crit_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      ve_q <= 1'b0;
    end else if (adv) begin
      va_q <= in_valid_i;
      vb_q <= va_q;
      vc_q <= vb_q;
      vd_q <= sq_valid;
      ve_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mxi_a_q <= mxi_a_d;
      sb_a_q  <= sb_a_d;
      for (int i = 0; i < 3; i++) begin
        sqxi_b_q[i] <= mxi_a_q[i] * mxi_a_q[i];
        sqd_b_q[i]  <= sb_a_q.md[i] * sb_a_q.md[i];
      end
      sb_b_q     <= sb_a_q;
      rad_c_q[0] <= RAD_W'(sqxi_b_q[0]) + RAD_W'(sqxi_b_q[1]) + RAD_W'(sqxi_b_q[2]);
      rad_c_q[1] <= sqd_b_q[0] + sqd_b_q[1] + sqd_b_q[2];
      sb_c_q     <= sb_b_q;
      num_q      <= num_d;
      den_q      <= den_d;
      dsb_q      <= dsb_d;
      fin_q      <= fin_d;
    end
  end

  pbf_sqrt_pipe u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (vc_q),
    .rad_i   (rad_c_q),
    .sb_i    (sb_c_q),
    .valid_o (sq_valid),
    .root_o  (root),
    .sb_o    (sq_sb)
  );

  pbf_div_pipe u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (vd_q),
    .num_i   (num_q),
    .den_i   (den_q),
    .sb_i    (dsb_q),
    .valid_o (dv_valid),
    .quo_o   (quo),
    .sb_o    (dv_sb)
  );

  pbf_force_mul u_force (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (ve_q),
    .fin_i   (fin_q),
    .micro_i (micro_q),
    .valid_o (out_valid_o),
    .out_o   (out_data_o)
  );

  `ASSERT_IMPLY(a_flag_zero_force, clk_i, rst_ni,
    out_valid_o && (out_data_o.broken_now || out_data_o.length_error),
    out_data_o.force_x == '0 && out_data_o.force_y == '0 && out_data_o.force_z == '0)
  `ASSERT_IMPLY(a_flags_exclusive, clk_i, rst_ni,
    out_valid_o, !(out_data_o.broken_now && out_data_o.length_error))
  `ASSERT_IMPLY(a_stall_blocks_input, clk_i, rst_ni,
    out_valid_o && !out_ready_i, !in_ready_o)
  `ASSERT_NEXT(a_stall_holds_word, clk_i, rst_ni,
    out_valid_o && !out_ready_i && !cfg_we_i, out_valid_o && $stable(out_data_o))

endmodule
`default_nettype wire

// ===== rtl/pbf_sqrt_pipe.sv =====
// ----------------------------------------------------------------------------
// pbf_sqrt_pipe
// Two-lane pipelined integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module pbf_sqrt_pipe (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               en_i,
  input  logic                               valid_i,
  input  logic [1:0][pbf_pkg::RAD_W-1:0]     rad_i,
  input  pbf_pkg::sqrt_sb_t                  sb_i,
  output logic                               valid_o,
  output logic [1:0][pbf_pkg::LEN_W-1:0]     root_o,
  output pbf_pkg::sqrt_sb_t                  sb_o
);
  import pbf_pkg::*;

  localparam int unsigned N     = LEN_W;
  localparam int unsigned PAD_W = 2 * LEN_W;
  localparam int unsigned REM_W = LEN_W + 3;

  logic [N-1:0]             vld_q, vld_d;
  sqrt_sb_t                 sb_q   [N];
  sqrt_sb_t                 sb_d   [N];
  logic [1:0][PAD_W-1:0]    rad_q  [N];
  logic [1:0][PAD_W-1:0]    rad_d  [N];
  logic [1:0][REM_W-1:0]    rem_q  [N];
  logic [1:0][REM_W-1:0]    rem_d  [N];
  logic [1:0][LEN_W-1:0]    root_q [N];
  logic [1:0][LEN_W-1:0]    root_d [N];

  always_comb begin
    logic [PAD_W-1:0] rad_s;
    logic [REM_W-1:0] rem_s;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic [LEN_W-1:0] root_s;
    vld_d = {vld_q[N-2:0], valid_i};
    for (int g = 0; g < N; g++) begin
      if (g == 0) begin
        sb_d[g] = sb_i;
      end else begin
        sb_d[g] = sb_q[g-1];
      end
      for (int l = 0; l < 2; l++) begin
        if (g == 0) begin
          rad_s  = PAD_W'(rad_i[l]);
          rem_s  = '0;
          root_s = '0;
        end else begin
          rad_s  = rad_q[g-1][l];
          rem_s  = rem_q[g-1][l];
          root_s = root_q[g-1][l];
        end
        // bring down the next two radicand bits, try root*4+1
        rem_sh = {rem_s[REM_W-3:0], rad_s[PAD_W-1 -: 2]};
        trial  = REM_W'({root_s, 2'b01});
        rad_d[g][l] = {rad_s[PAD_W-3:0], 2'b00};
        if (rem_sh >= trial) begin
          rem_d[g][l]  = rem_sh - trial;
          root_d[g][l] = {root_s[LEN_W-2:0], 1'b1};
        end else begin
          rem_d[g][l]  = rem_sh;
          root_d[g][l] = {root_s[LEN_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sb_q   <= sb_d;
      rad_q  <= rad_d;
      rem_q  <= rem_d;
      root_q <= root_d;
    end
  end

  assign valid_o = vld_q[N-1];
  assign root_o  = root_q[N-1];
  assign sb_o    = sb_q[N-1];

endmodule
`default_nettype wire

// ===== rtl/pbf_div_pipe.sv =====
// ----------------------------------------------------------------------------
// pbf_div_pipe
// Four-lane pipelined restoring divider, (num << 30) / den, one bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none
module pbf_div_pipe (
  input  logic                                              clk_i,
  input  logic                                              rst_ni,
  input  logic                                              en_i,
  input  logic                                              valid_i,
  input  logic [pbf_pkg::DIV_LANES-1:0][pbf_pkg::LEN_W-1:0] num_i,
  input  logic [pbf_pkg::DIV_LANES-1:0][pbf_pkg::LEN_W-1:0] den_i,
  input  pbf_pkg::div_sb_t                                  sb_i,
  output logic                                              valid_o,
  output logic [pbf_pkg::DIV_LANES-1:0][pbf_pkg::Q_W-1:0]   quo_o,
  output pbf_pkg::div_sb_t                                  sb_o
);
  import pbf_pkg::*;

  localparam int unsigned N = Q_W;
  localparam int unsigned L = DIV_LANES;

  logic [N-1:0]            vld_q, vld_d;
  div_sb_t                 sb_q  [N];
  div_sb_t                 sb_d  [N];
  logic [L-1:0][LEN_W-1:0] rem_q [N];
  logic [L-1:0][LEN_W-1:0] rem_d [N];
  logic [L-1:0][LEN_W-1:0] den_q [N];
  logic [L-1:0][LEN_W-1:0] den_d [N];
  logic [L-1:0][Q_W-1:0]   quo_q [N];
  logic [L-1:0][Q_W-1:0]   quo_d [N];

  always_comb begin
    logic [LEN_W-1:0] rem_s;
    logic [LEN_W-1:0] den_s;
    logic [Q_W-1:0]   quo_s;
    logic             bit_in;
    logic [LEN_W:0]   rem_sh;
    vld_d = {vld_q[N-2:0], valid_i};
    for (int g = 0; g < N; g++) begin
      if (g == 0) begin
        sb_d[g] = sb_i;
      end else begin
        sb_d[g] = sb_q[g-1];
      end
      for (int l = 0; l < L; l++) begin
        // the dividend's bits above the quotient field seed the remainder
        if (g == 0) begin
          rem_s  = LEN_W'(num_i[l][LEN_W-1:1]);
          bit_in = num_i[l][0];
          den_s  = den_i[l];
          quo_s  = '0;
        end else begin
          rem_s  = rem_q[g-1][l];
          bit_in = 1'b0;
          den_s  = den_q[g-1][l];
          quo_s  = quo_q[g-1][l];
        end
        rem_sh = {rem_s, bit_in};
        den_d[g][l] = den_s;
        if (rem_sh >= {1'b0, den_s}) begin
          rem_d[g][l] = LEN_W'(rem_sh - {1'b0, den_s});
          quo_d[g][l] = {quo_s[Q_W-2:0], 1'b1};
        end else begin
          rem_d[g][l] = rem_sh[LEN_W-1:0];
          quo_d[g][l] = {quo_s[Q_W-2:0], 1'b0};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sb_q  <= sb_d;
      rem_q <= rem_d;
      den_q <= den_d;
      quo_q <= quo_d;
    end
  end

  assign valid_o = vld_q[N-1];
  assign quo_o   = quo_q[N-1];
  assign sb_o    = sb_q[N-1];

endmodule
`default_nettype wire

// ===== rtl/pbf_force_mul.sv =====
// ----------------------------------------------------------------------------
// pbf_force_mul
// Force scaling: k = |s| * c, then unit * k, saturate, and result select.
// ----------------------------------------------------------------------------
`default_nettype none
module pbf_force_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  pbf_pkg::force_in_t            fin_i,
  input  logic [pbf_pkg::MICRO_W-1:0]   micro_i,
  output logic                          valid_o,
  output pbf_pkg::out_word_t            out_o
);
  import pbf_pkg::*;

  localparam int unsigned C_LO   = MICRO_W / 2;
  localparam int unsigned C_HI   = MICRO_W - C_LO;
  localparam int unsigned KPL_W  = Q_W + C_LO;
  localparam int unsigned KPH_W  = Q_W + C_HI;
  localparam int unsigned KS_W   = KPH_W + C_LO;
  localparam int unsigned K_W    = KS_W - CRIT_W;
  localparam int unsigned K_LO   = 25;
  localparam int unsigned K_HI   = K_W - K_LO;
  localparam int unsigned FPL_W  = Q_W + K_LO;
  localparam int unsigned FPH_W  = Q_W + K_HI;
  localparam int unsigned FS_W   = FPH_W + K_LO;

  logic [3:0]                 vld_q;
  force_in_t                  f1_q, f2_q, f3_q;
  logic [KPL_W-1:0]           kpl_q;
  logic [KPH_W-1:0]           kph_q;
  logic [K_W-1:0]             k_q;
  logic [KS_W-1:0]            ksum;
  logic [2:0][FPL_W-1:0]      fpl_q;
  logic [2:0][FPH_W-1:0]      fph_q;
  out_word_t                  out_q, out_d;

  assign ksum = {kph_q, {C_LO{1'b0}}} + KS_W'(kpl_q);

  always_comb begin
    logic [FS_W-1:0]        fsum;
    logic [F_W-1:0]         f;
    logic [F_W-1:0]         fm;
    logic                   neg;
    logic [2:0][FORCE_W-1:0] frc;
    for (int i = 0; i < 3; i++) begin
      fsum = {fph_q[i], {K_LO{1'b0}}} + FS_W'(fpl_q[i]);
      f    = fsum[FS_W-1 -: F_W];
      neg  = f3_q.dneg[i] ^ f3_q.sneg;
      if (neg) begin
        fm     = (f > F_NEG_LIM) ? F_NEG_LIM : f;
        frc[i] = FORCE_W'(0) - fm[FORCE_W-1:0];
      end else begin
        fm     = (f > F_POS_LIM) ? F_POS_LIM : f;
        frc[i] = fm[FORCE_W-1:0];
      end
    end
    out_d = '0;
    if (f3_q.was_broken) begin
      out_d.broken_now = 1'b1;
    end else if (f3_q.l0_zero) begin
      out_d.length_error = 1'b1;
    end else if (f3_q.brk) begin
      out_d.stretch    = f3_q.stretch;
      out_d.broken_now = 1'b1;
    end else if (f3_q.l1_zero) begin
      out_d.stretch      = f3_q.stretch;
      out_d.length_error = 1'b1;
    end else begin
      out_d.stretch = f3_q.stretch;
      out_d.force_x = frc[0];
      out_d.force_y = frc[1];
      out_d.force_z = frc[2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      f1_q  <= fin_i;
      kpl_q <= fin_i.sm * micro_i[C_LO-1:0];
      kph_q <= fin_i.sm * micro_i[MICRO_W-1:C_LO];
      f2_q  <= f1_q;
      k_q   <= ksum[KS_W-1:CRIT_W];
      f3_q  <= f2_q;
      for (int i = 0; i < 3; i++) begin
        fpl_q[i] <= f2_q.u[i] * k_q[K_LO-1:0];
        fph_q[i] <= f2_q.u[i] * k_q[K_W-1:K_LO];
      end
      out_q <= out_d;
    end
  end

  assign valid_o = vld_q[3];
  assign out_o   = out_q;

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the PMB bond force core. Bonds are driven over the
// valid/ready input, each accepted word is run through a local fixed-point
// model of stretch, breaking and force, and every output word is compared
// field by field with the oldest predicted word. Directed corner cases come
// first. Random bonds then run under several register settings and idle
// patterns, with one long output hold-off that fills the pipeline.
// ----------------------------------------------------------------------------
`default_nettype none
module tb_top;
  import pbf_pkg::*;

  localparam int unsigned WATCHDOG_LIM = 5000;
  localparam int unsigned DRAIN_CYC    = 90;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
  localparam logic [63:0] M30 = 64'h3FFF_FFFF;
  localparam logic [63:0] FMAX = 64'h7FFF_FFFF_FFFF;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  in_word_t in_data_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_word_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  logic [CRIT_W-1:0] crit_q;
  logic [MICRO_W-1:0] micro_q;
  out_word_t exp_forces[$];
  int unsigned snd_idle = 0;
  int unsigned rcv_stall = 0;
  int unsigned hold_off_cycles = 0;
  int unsigned quiet_cnt = 0;
  int unsigned fail_cnt = 0;

  pmb_bond_force_and_break_core uut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .in_data_i,
    .out_valid_o, .out_ready_i, .out_data_o, .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  function automatic logic [63:0] mag64(longint v);
    return v < 0 ? 64'(-v) : 64'(v);
  endfunction

  // floor(sqrt(a^2 + b^2 + c^2)), one root bit per step
  function automatic logic [63:0] bond_len(longint a, longint b, longint c);
    logic [127:0] sum;
    logic [127:0] cand;
    logic [63:0] r;
    sum = 128'(mag64(a)) * mag64(a) + 128'(mag64(b)) * mag64(b)
        + 128'(mag64(c)) * mag64(c);
    r = '0;
    for (int bit_i = 34; bit_i >= 0; bit_i--) begin
      cand = 128'(r | (64'd1 << bit_i));
      if (cand * cand <= sum) r = cand[63:0];
    end
    return r;
  endfunction

  function automatic out_word_t calc_bond(in_word_t w);
    out_word_t o;
    longint xi[3];
    longint d[3];
    logic [63:0] l0, l1, diff, sm, k, u, f;
    longint s;
    logic neg;
    o = '0;
    if (w.was_broken) begin
      o.broken_now = 1'b1;
      return o;
    end
    xi[0] = longint'(w.ref_dx);
    xi[1] = longint'(w.ref_dy);
    xi[2] = longint'(w.ref_dz);
    d[0] = xi[0] + longint'(w.rel_disp_x);
    d[1] = xi[1] + longint'(w.rel_disp_y);
    d[2] = xi[2] + longint'(w.rel_disp_z);
    l0 = bond_len(xi[0], xi[1], xi[2]);
    if (l0 == 0) begin
      o.length_error = 1'b1;
      return o;
    end
    l1 = bond_len(d[0], d[1], d[2]);
    if (l1 >= l0) begin
      diff = l1 - l0;
      if (diff >= 2 * l0) s = 64'h7FFF_FFFF;
      else s = longint'((diff << 30) / l0);
    end else begin
      s = -longint'(((l0 - l1) << 30) / l0);
    end
    o.stretch = s[31:0];
    if (!w.mode && s > longint'(crit_q)) begin
      o.broken_now = 1'b1;
      return o;
    end
    if (l1 == 0) begin
      o.length_error = 1'b1;
      return o;
    end
    sm = mag64(s);
    k = sm * (64'(micro_q) >> 30) + ((sm * (64'(micro_q) & M30)) >> 30);
    for (int i = 0; i < 3; i++) begin
      u = (mag64(d[i]) << 30) / l1;
      f = u * (k >> 30) + ((u * (k & M30)) >> 30);
      neg = (d[i] < 0) != (s < 0);
      if (neg) begin
        if (f > FMAX + 1) f = FMAX + 1;
        f = -f;
      end else if (f > FMAX) begin
        f = FMAX;
      end
      case (i)
        0: o.force_x = f[47:0];
        1: o.force_y = f[47:0];
        default: o.force_z = f[47:0];
      endcase
    end
    return o;
  endfunction

  // predict on every accepted input word
  always @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) exp_forces.push_back(calc_bond(in_data_i));
  end

  always @(posedge clk_i) begin
    if (hold_off_cycles > 0) begin
      out_ready_i <= 1'b0;
      hold_off_cycles--;
    end else begin
      out_ready_i <= ($urandom_range(99) >= rcv_stall);
    end
  end

  always @(posedge clk_i) begin
    out_word_t e;
    if (out_valid_o && out_ready_i) begin
      if (exp_forces.size() == 0) begin
        $error("output word with nothing expected");
        fail_cnt++;
      end else begin
        e = exp_forces.pop_front();
        if (out_data_o.force_x !== e.force_x) begin
          $error("force_x exp %h got %h", e.force_x, out_data_o.force_x); fail_cnt++;
        end
        if (out_data_o.force_y !== e.force_y) begin
          $error("force_y exp %h got %h", e.force_y, out_data_o.force_y); fail_cnt++;
        end
        if (out_data_o.force_z !== e.force_z) begin
          $error("force_z exp %h got %h", e.force_z, out_data_o.force_z); fail_cnt++;
        end
        if (out_data_o.stretch !== e.stretch) begin
          $error("stretch exp %h got %h", e.stretch, out_data_o.stretch); fail_cnt++;
        end
        if (out_data_o.broken_now !== e.broken_now) begin
          $error("broken_now exp %b got %b", e.broken_now, out_data_o.broken_now);
          fail_cnt++;
        end
        if (out_data_o.length_error !== e.length_error) begin
          $error("length_error exp %b got %b", e.length_error, out_data_o.length_error);
          fail_cnt++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cnt <= 0;
    else quiet_cnt <= quiet_cnt + 1;
    if (quiet_cnt >= WATCHDOG_LIM) begin
      $display("Verification failed");
      $finish;
    end
  end

  // hold valid high between back-to-back words; only drop it on an idle gap
  task automatic send_bond(in_word_t w);
    if ($urandom_range(99) < snd_idle) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < snd_idle);
    end
    in_valid_i <= 1'b1;
    in_data_i <= w;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic drain_pipe();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (exp_forces.size() != 0);
    repeat (DRAIN_CYC) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    if (idx == CFG_CRIT) crit_q = val[CRIT_W-1:0];
    else if (idx == CFG_MICRO) micro_q = val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  function automatic in_word_t mk_bond(longint x, longint y, longint z,
                                       longint ex, longint ey, longint ez,
                                       logic brk, logic md);
    in_word_t w;
    w.ref_dx = x[31:0]; w.ref_dy = y[31:0]; w.ref_dz = z[31:0];
    w.rel_disp_x = ex[31:0]; w.rel_disp_y = ey[31:0]; w.rel_disp_z = ez[31:0];
    w.was_broken = brk;
    w.mode = md;
    return w;
  endfunction

  // mostly physical bonds with small strain, some raw noise
  function automatic in_word_t rand_bond();
    in_word_t w;
    int signed xi[3];
    int signed eta[3];
    if ($urandom_range(9) == 0) begin
      w = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           2'($urandom)};
      return w;
    end
    for (int i = 0; i < 3; i++) begin
      xi[i] = $signed($urandom) >>> $urandom_range(0, 14);
      eta[i] = (xi[i] >>> $urandom_range(3, 12))
             + ($signed($urandom) >>> $urandom_range(12, 31));
    end
    return mk_bond(xi[0], xi[1], xi[2], eta[0], eta[1], eta[2],
                   $urandom_range(9) == 0, 1'($urandom));
  endfunction

  task automatic test_directed();
    longint mx, mn;
    mx = 64'sd2147483647;
    mn = -64'sd2147483648;
    send_bond(mk_bond(0, 0, 0, 5, 6, 7, 1'b0, 1'b0));
    send_bond(mk_bond(0, 0, 0, 5, 6, 7, 1'b0, 1'b1));
    send_bond(mk_bond(65536, 0, 0, 100, 0, 0, 1'b1, 1'b0));
    send_bond(mk_bond(65536, 0, 0, 100, 0, 0, 1'b0, 1'b0));
    send_bond(mk_bond(65536, 0, 0, 6554, 0, 0, 1'b0, 1'b0));
    send_bond(mk_bond(65536, 0, 0, 6554, 0, 0, 1'b0, 1'b1));
    send_bond(mk_bond(65536, -65536, 0, -6554, 6554, 0, 1'b0, 1'b0));
    send_bond(mk_bond(65536, 65536, 65536, -65536, -65536, -65536, 1'b0, 1'b1));
    send_bond(mk_bond(65536, 65536, 65536, -65536, -65536, -65536, 1'b0, 1'b0));
    send_bond(mk_bond(1, 0, 0, mx, 0, 0, 1'b0, 1'b1));
    send_bond(mk_bond(1, 0, 0, mx, 0, 0, 1'b0, 1'b0));
    send_bond(mk_bond(mx, mx, mx, mx, mx, mx, 1'b0, 1'b1));
    send_bond(mk_bond(mn, mn, mn, mn, mn, mn, 1'b0, 1'b1));
    send_bond(mk_bond(mn, mn, mn, mx, mx, mx, 1'b0, 1'b0));
    send_bond(mk_bond(mx, mn, mx, mn, mx, mn, 1'b0, 1'b1));
    send_bond(mk_bond(mn, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    send_bond(mk_bond(mx, mn, mx, -1, -1, -1, 1'b1, 1'b1));
    send_bond(mk_bond(3, -4, 12, 1, 1, -1, 1'b0, 1'b1));
    drain_pipe();
    // saturate the force with the largest modulus
    write_reg(CFG_MICRO, '1);
    write_reg(CFG_CRIT, 48'h3FFF_FFFF);
    send_bond(mk_bond(1, 0, 0, mx, 0, 0, 1'b0, 1'b1));
    send_bond(mk_bond(-1, 1, 0, mn, mx, 0, 1'b0, 1'b0));
    send_bond(mk_bond(65536, 0, 0, -60000, 0, 0, 1'b0, 1'b0));
    send_bond(mk_bond(1, 1, 1, mx, mn, mx, 1'b0, 1'b0));
    drain_pipe();
    write_reg(CFG_CRIT, 48'd0);
    write_reg(CFG_MICRO, 48'd0);
    send_bond(mk_bond(65536, 0, 0, 1, 0, 0, 1'b0, 1'b0));
    send_bond(mk_bond(65536, 0, 0, -1, 0, 0, 1'b0, 1'b0));
    send_bond(mk_bond(65536, 0, 0, 0, 0, 0, 1'b0, 1'b0));
    drain_pipe();
    // out-of-range indexes must not disturb either register
    write_reg(CFG_SPARE_A, '1);
    write_reg(CFG_SPARE_B, 48'h1234_5678_9ABC);
    send_bond(mk_bond(65536, 0, 0, 4000, 0, 0, 1'b0, 1'b1));
    drain_pipe();
  endtask

  task automatic test_random_phase(int unsigned s_idle, int unsigned r_stall,
                                   logic [CFG_DATA_W-1:0] crit,
                                   logic [CFG_DATA_W-1:0] micro, int n);
    write_reg(CFG_CRIT, crit);
    write_reg(CFG_MICRO, micro);
    snd_idle = s_idle;
    rcv_stall = r_stall;
    @(posedge clk_i);
    for (int i = 0; i < n; i++) send_bond(rand_bond());
    drain_pipe();
  endtask

  task automatic test_backpressure();
    snd_idle = 0;
    rcv_stall = 0;
    @(posedge clk_i);
    hold_off_cycles = 300;
    for (int i = 0; i < 120; i++) send_bond(rand_bond());
    drain_pipe();
  endtask

  initial begin
    crit_q = CRIT_RESET;
    micro_q = MICRO_RESET;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_phase(0, 0, 48'(CRIT_RESET), MICRO_RESET, 100);
    test_random_phase(86, 0, 48'd53687091, 48'h0000_0100_0000, 100);
    test_random_phase(0, 86, 48'h3FFF_FFFF, 48'hFFFF_FFFF_FFFF, 100);
    test_random_phase(26, 26, 48'($urandom_range(0, 32'h3FFF_FFFF)),
                      {$urandom, 16'($urandom)}, 100);
    test_random_phase(0, 0, 48'd0, 48'd65536, 60);
    test_backpressure();
    if (fail_cnt == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
